// ===== hw/rtl/lss_pkg.sv =====
// Shared types and constants of the literal substring search block.
package lss_pkg;

  localparam int DATA_W           = 64;
  localparam int CNT_W            = 4;
  localparam int LEN_W            = 5;
  localparam int OFS_W            = 32;
  localparam int NEEDLE_REG_BYTES = 16;
  localparam int SEEN_LO_W        = 6;

  typedef enum logic [1:0] {
    CFG_NEEDLE_LOW  = 2'd0,
    CFG_NEEDLE_HIGH = 2'd1,
    CFG_NEEDLE_LEN  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [DATA_W-1:0] chunk_data;
    logic [CNT_W-1:0]  byte_cnt;
    logic              is_last;
  } in_t;

  typedef struct packed {
    logic             found;
    logic [OFS_W-1:0] match_offset;
  } out_t;

  typedef struct packed {
    logic             accept;
    logic             last;
    logic [LEN_W-1:0] len;
  } step_t;

endpackage

// ===== hw/rtl/lss_lane.sv =====
// One compare lane: checks for a needle match that ends at a fixed byte of the chunk.
module lss_lane import lss_pkg::*; #(
  parameter int MAX_NEEDLE = 16,
  parameter int LANE_IDX   = 0
) (
  input  logic [MAX_NEEDLE*8-1:0] win_i,
  input  logic [MAX_NEEDLE*8-1:0] needle_i,
  input  logic [LEN_W-1:0]        len_i,
  input  logic [CNT_W-1:0]        count_i,
  input  logic [SEEN_LO_W-1:0]    seen_i,
  output logic                    hit_o
);

  logic eq;
  logic enough;
  logic fits;

  always_comb begin
    eq = 1'b1;
    for (int k = 0; k < MAX_NEEDLE; k++) begin
      if ((7'(k) < {2'b00, len_i}) && (win_i[k*8 +: 8] != needle_i[k*8 +: 8])) begin
        eq = 1'b0;
      end
    end
  end

  assign enough = (7'(seen_i) + 7'(LANE_IDX + 1)) >= {2'b00, len_i};
  assign fits   = {2'b00, len_i} <= 7'(MAX_NEEDLE);
  assign hit_o  = eq & enough & fits & (CNT_W'(LANE_IDX) < count_i);

endmodule

// ===== hw/rtl/lss_merge.sv =====
// Merge stage: picks the first lane hit, forms the result and buffers it for the receiver.
module lss_merge import lss_pkg::*; #(
  parameter int CAP         = 8,
  parameter int OFFSET_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  step_t                  step_i,
  input  logic [CAP-1:0]         hits_i,
  input  logic [OFFSET_BITS-1:0] seen_i,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output out_t                   out_data_o,
  output logic                   in_ready_o
);

  localparam int SEL_W = (CAP > 1) ? $clog2(CAP) : 1;

  logic                           any_hit;
  logic [SEL_W-1:0]               sel;
  logic [OFFSET_BITS:0]           cnt;
  logic [OFFSET_BITS-1:0]         cnt_sat;
  logic [OFFSET_BITS-1:0]         off;
  logic [OFFSET_BITS+OFS_W-1:0]   off_ext;
  logic                           res_valid;
  out_t                           res;
  logic                           ag_d, ag_q;
  logic                           out_valid_d, out_valid_q;
  logic                           skid_valid_d, skid_valid_q;
  out_t                           out_d, out_q;
  out_t                           skid_d, skid_q;

  always_comb begin
    any_hit = 1'b0;
    sel     = '0;
    for (int j = CAP - 1; j >= 0; j--) begin
      if (hits_i[j]) begin
        any_hit = 1'b1;
        sel     = SEL_W'(j);
      end
    end
  end

  assign cnt     = {1'b0, seen_i} + (OFFSET_BITS + 1)'(sel) + (OFFSET_BITS + 1)'(1);
  assign cnt_sat = cnt[OFFSET_BITS] ? '1 : cnt[OFFSET_BITS-1:0];
  assign off     = cnt_sat - OFFSET_BITS'(step_i.len);
  assign off_ext = {{OFS_W{1'b0}}, off};

  always_comb begin
    res_valid = 1'b0;
    res       = '0;
    if (step_i.accept && !ag_q) begin
      if (step_i.len == '0) begin
        res_valid = 1'b1;
        res.found = 1'b1;
      end else if (any_hit) begin
        res_valid        = 1'b1;
        res.found        = 1'b1;
        res.match_offset = off_ext[OFS_W-1:0];
      end else if (step_i.last) begin
        res_valid = 1'b1;
      end
    end
  end

  always_comb begin
    ag_d = ag_q;
    if (step_i.accept) begin
      ag_d = step_i.last ? 1'b0 : (ag_q | res_valid);
    end
  end

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (!out_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = res_valid;
        skid_d       = res;
      end else begin
        out_valid_d = res_valid;
        out_d       = res;
      end
    end else if (res_valid) begin
      skid_valid_d = 1'b1;
      skid_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ag_q         <= 1'b0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      ag_q         <= ag_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign in_ready_o  = !skid_valid_q;

endmodule

// ===== hw/rtl/literal_substring_search_top.sv =====
// Top level of the streaming literal substring search block.
// The block looks for the first occurrence of a configured needle of up to
// MAX_NEEDLE bytes in a haystack that arrives as chunks of up to eight bytes.
// The input channel carries one chunk per transaction; is_last ends the
// haystack. The output channel carries at most one transaction per haystack:
// found with the start offset of the first match, or not-found at the end.
// The user must set the needle through the write port only while the block
// is idle; the block itself does not enforce this. One chunk is taken every
// cycle while in_ready_o is high; each lane compares one end position of the
// chunk against the needle; each result is registered in the output buffer.
// Reset clears the needle to empty, the byte position and the answer flag.
// The output side has a two-entry buffer: when the receiver stalls, the
// block keeps taking chunks until both entries hold results, and then
// drops in_ready_o until the receiver takes one.
module literal_substring_search_top import lss_pkg::*; #(
  parameter int MAX_NEEDLE  = 16,
  parameter int LANES       = 8,
  parameter int OFFSET_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_t               in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_t              out_data_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [DATA_W-1:0] cfg_wdata_i
);

  localparam int W   = MAX_NEEDLE - 1;
  localparam int CAP = (LANES < 8) ? LANES : 8;
  localparam int EXT = W + CAP;
  localparam int NB  = MAX_NEEDLE * 8;

  logic [DATA_W-1:0]      ndl_lo_q, ndl_hi_q;
  logic [LEN_W-1:0]       ndl_len_q;
  logic [7:0]             ndl_byte [NEEDLE_REG_BYTES];
  logic [NB-1:0]          ndl_al;
  logic [CNT_W-1:0]       count;
  logic [7:0]             ext [EXT];
  logic [7:0]             win_d [W];
  logic [7:0]             win_q [W];
  logic [OFFSET_BITS-1:0] bs_d, bs_q;
  logic [OFFSET_BITS:0]   bs_sum;
  logic [SEEN_LO_W-1:0]   bs_lo;
  logic                   in_acc;
  logic [CAP-1:0]         hits;
  step_t                  step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ndl_lo_q  <= '0;
      ndl_hi_q  <= '0;
      ndl_len_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_NEEDLE_LOW:  ndl_lo_q  <= cfg_wdata_i;
        CFG_NEEDLE_HIGH: ndl_hi_q  <= cfg_wdata_i;
        CFG_NEEDLE_LEN:  ndl_len_q <= cfg_wdata_i[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < NEEDLE_REG_BYTES; i++) begin
      if (i < 8) begin
        ndl_byte[i] = ndl_lo_q[8*i +: 8];
      end else begin
        ndl_byte[i] = ndl_hi_q[8*(i-8) +: 8];
      end
    end
  end

  always_comb begin
    int n;
    for (int k = 0; k < MAX_NEEDLE; k++) begin
      n = int'(ndl_len_q) - 1 - k;
      if (n >= 0 && n < NEEDLE_REG_BYTES) begin
        ndl_al[k*8 +: 8] = ndl_byte[n[3:0]];
      end else begin
        ndl_al[k*8 +: 8] = '0;
      end
    end
  end

  assign in_acc = in_valid_i & in_ready_o;
  assign count  = (in_data_i.byte_cnt > CNT_W'(CAP)) ? CNT_W'(CAP) : in_data_i.byte_cnt;

  always_comb begin
    for (int i = 0; i < W; i++) begin
      ext[i] = win_q[i];
    end
    for (int j = 0; j < CAP; j++) begin
      ext[W+j] = in_data_i.chunk_data[8*j +: 8];
    end
  end

  always_comb begin
    for (int i = 0; i < W; i++) begin
      win_d[i] = win_q[i];
      for (int c = 0; c <= CAP; c++) begin
        if (count == CNT_W'(c)) begin
          win_d[i] = ext[i+c];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      win_q <= win_d;
    end
  end

  assign bs_sum = {1'b0, bs_q} + (OFFSET_BITS + 1)'(count);

  always_comb begin
    bs_d = bs_q;
    if (in_acc) begin
      if (in_data_i.is_last) begin
        bs_d = '0;
      end else begin
        bs_d = bs_sum[OFFSET_BITS] ? '1 : bs_sum[OFFSET_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bs_q <= '0;
    end else begin
      bs_q <= bs_d;
    end
  end

  assign bs_lo = (|bs_q[OFFSET_BITS-1:SEEN_LO_W]) ? '1 : bs_q[SEEN_LO_W-1:0];

  for (genvar j = 0; j < CAP; j++) begin : g_lane
    logic [NB-1:0] lane_win;
    for (genvar k = 0; k < MAX_NEEDLE; k++) begin : g_tap
      assign lane_win[k*8 +: 8] = ext[W+j-k];
    end
    lss_lane #(
      .MAX_NEEDLE (MAX_NEEDLE),
      .LANE_IDX   (j)
    ) u_lane (
      .win_i    (lane_win),
      .needle_i (ndl_al),
      .len_i    (ndl_len_q),
      .count_i  (count),
      .seen_i   (bs_lo),
      .hit_o    (hits[j])
    );
  end

  assign step.accept = in_acc;
  assign step.last   = in_data_i.is_last;
  assign step.len    = ndl_len_q;

  lss_merge #(
    .CAP         (CAP),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .hits_i      (hits),
    .seen_i      (bs_q),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .in_ready_o  (in_ready_o)
  );

  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled while no result is pending");

  a_clear_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.is_last) |=> (bs_q == '0))
    else $error("byte position not cleared after the last chunk");

  a_position_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !in_data_i.is_last) |=> (bs_q >= $past(bs_q)))
    else $error("byte position went backward within a haystack");

  a_position_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_acc |=> $stable(bs_q))
    else $error("byte position changed without a transaction");

endmodule
